// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational property checked at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/mrtt_pkg.sv -----
// types and constants of the multi-rate tick timer bank
`timescale 1ns / 1ps

package mrtt_pkg;

  localparam int TICKS_PER_MS = 20;

  localparam logic [7:0] RELOAD_SHORT  = 8'(3 * TICKS_PER_MS);
  localparam logic [7:0] RELOAD_BASE   = 8'(10 * TICKS_PER_MS);
  localparam logic [3:0] RELOAD_TENTH  = 4'd10;
  localparam logic [5:0] RELOAD_HALF   = 6'd50;
  localparam logic [6:0] RELOAD_MINUTE = 7'd120;

  localparam int NUM_CD = 6;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // countdown slots, also the timer_select codes
  localparam logic [2:0] CD_SHORT  = 3'd0;
  localparam logic [2:0] CD_LONG   = 3'd1;
  localparam logic [2:0] CD_REPEAT = 3'd2;
  localparam logic [2:0] CD_BEEP   = 3'd3;
  localparam logic [2:0] CD_ALARM  = 3'd4;
  localparam logic [2:0] CD_SNOOZE = 3'd5;

  typedef struct packed {
    logic [7:0]             pre_short;
    logic [7:0]             pre_base;
    logic [3:0]             pre_tenth;
    logic [5:0]             pre_half;
    logic [6:0]             pre_minute;
    logic                   tog_slow;
    logic                   tog_fast;
    logic [NUM_CD-1:0][7:0] cd;
  } mrtt_state_t;

  typedef struct packed {
    logic       display_strobe;
    logic       debounce_strobe;
    logic       beep_off_pulse;
    logic       blink_slow;
    logic       blink_fast;
    logic [7:0] short_user_left;
    logic [7:0] long_user_left;
    logic [7:0] repeat_left;
    logic [7:0] beep_left;
    logic [7:0] alarm_left;
    logic [7:0] snooze_left;
  } mrtt_result_t;

  function automatic logic [7:0] dec_sat(input logic [7:0] v);
    dec_sat = (v != 8'd0) ? v - 8'd1 : v;
  endfunction

endpackage

// ----- sv/mrtt_if.sv -----
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps

interface mrtt_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] timer_select;
  logic [7:0] load_value;

  modport source (output valid, output command, output timer_select,
                  output load_value, input ready);
  modport sink (input valid, input command, input timer_select,
                input load_value, output ready);
endinterface

interface mrtt_out_if;
  logic       valid;
  logic       ready;
  logic       display_strobe;
  logic       debounce_strobe;
  logic       beep_off_pulse;
  logic       blink_slow;
  logic       blink_fast;
  logic [7:0] short_user_left;
  logic [7:0] long_user_left;
  logic [7:0] repeat_left;
  logic [7:0] beep_left;
  logic [7:0] alarm_left;
  logic [7:0] snooze_left;

  modport source (output valid, output display_strobe, output debounce_strobe,
                  output beep_off_pulse, output blink_slow, output blink_fast,
                  output short_user_left, output long_user_left,
                  output repeat_left, output beep_left, output alarm_left,
                  output snooze_left, input ready);
  modport sink (input valid, input display_strobe, input debounce_strobe,
                input beep_off_pulse, input blink_slow, input blink_fast,
                input short_user_left, input long_user_left,
                input repeat_left, input beep_left, input alarm_left,
                input snooze_left, output ready);
endinterface

// ----- sv/mrtt_step.sv -----
// next-state and result logic for one command or tick
`timescale 1ns / 1ps

module mrtt_step import mrtt_pkg::*; (
  input  mrtt_state_t  st,
  input  logic         command,
  input  logic [2:0]   timer_select,
  input  logic [7:0]   load_value,
  output mrtt_state_t  st_nxt,
  output mrtt_result_t res
);

  logic strobe;
  logic debounce;
  logic beep_done;

  always_comb begin
    st_nxt    = st;
    strobe    = 1'b0;
    debounce  = 1'b0;
    beep_done = 1'b0;

    if (command == CMD_LOAD) begin
      // unused selector codes leave everything alone
      if (timer_select inside {[CD_SHORT:CD_SNOOZE]}) begin
        st_nxt.cd[timer_select] = load_value;
      end
    end else begin
      strobe = 1'b1;

      if (st.pre_short == 8'd0) begin
        st_nxt.pre_short    = RELOAD_SHORT;
        st_nxt.cd[CD_SHORT] = dec_sat(st.cd[CD_SHORT]);
      end else begin
        st_nxt.pre_short = st.pre_short - 8'd1;
      end

      if (st.pre_base == 8'd0) begin
        // base prescaler event
        st_nxt.pre_base      = RELOAD_BASE;
        debounce             = 1'b1;
        st_nxt.cd[CD_REPEAT] = dec_sat(st.cd[CD_REPEAT]);

        if (st.pre_tenth == 4'd0) begin
          st_nxt.pre_tenth   = RELOAD_TENTH;
          st_nxt.tog_fast    = ~st.tog_fast;
          st_nxt.cd[CD_LONG] = dec_sat(st.cd[CD_LONG]);
        end else begin
          st_nxt.pre_tenth = st.pre_tenth - 4'd1;
        end

        if (st.pre_half == 6'd0) begin
          st_nxt.pre_half = RELOAD_HALF;
          st_nxt.tog_slow = ~st.tog_slow;
          if (st.pre_minute == 7'd0) begin
            st_nxt.pre_minute = RELOAD_MINUTE;
            // snooze runs out before the alarm resumes
            if (st.cd[CD_SNOOZE] != 8'd0) begin
              st_nxt.cd[CD_SNOOZE] = st.cd[CD_SNOOZE] - 8'd1;
            end else begin
              st_nxt.cd[CD_ALARM] = dec_sat(st.cd[CD_ALARM]);
            end
          end else begin
            st_nxt.pre_minute = st.pre_minute - 7'd1;
          end
        end else begin
          st_nxt.pre_half = st.pre_half - 6'd1;
        end

        if (st.cd[CD_BEEP] != 8'd0) begin
          st_nxt.cd[CD_BEEP] = st.cd[CD_BEEP] - 8'd1;
          beep_done          = (st.cd[CD_BEEP] == 8'd1);
        end
      end else begin
        st_nxt.pre_base = st.pre_base - 8'd1;
      end
    end
  end

  always_comb begin
    res.display_strobe  = strobe;
    res.debounce_strobe = debounce;
    res.beep_off_pulse  = beep_done;
    res.blink_slow      = st_nxt.tog_slow;
    res.blink_fast      = st_nxt.tog_fast;
    res.short_user_left = st_nxt.cd[CD_SHORT];
    res.long_user_left  = st_nxt.cd[CD_LONG];
    res.repeat_left     = st_nxt.cd[CD_REPEAT];
    res.beep_left       = st_nxt.cd[CD_BEEP];
    res.alarm_left      = st_nxt.cd[CD_ALARM];
    res.snooze_left     = st_nxt.cd[CD_SNOOZE];
  end

endmodule

// ----- sv/multi_rate_tick_timer_bank.sv -----
// top level of the multi-rate tick timer bank
//
//  port     dir  role
//  in_if    in   tick or countdown load transaction
//  out_if   out  strobes, blink bits and all six countdowns
//
// one transaction per cycle while in_if.ready is high; each result appears in the cycle after acceptance
// the result register is the only buffer: in_if.ready is low only while it
// holds a result that out_if.ready does not take in that cycle
// synchronous active-low reset clears prescalers, toggles and countdowns
// no result is lost or repeated under any stall pattern on either side
`timescale 1ns / 1ps

module multi_rate_tick_timer_bank import mrtt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mrtt_in_if.sink    in_if,
  mrtt_out_if.source out_if
);

  mrtt_state_t  st_r;
  mrtt_state_t  st_nxt;
  mrtt_result_t res_nxt;
  mrtt_result_t res_r;
  logic         out_valid_r;
  logic         in_fire;

  assign in_if.ready = ~out_valid_r | out_if.ready;
  assign in_fire     = in_if.valid & in_if.ready;

  mrtt_step u_step (
    .st           (st_r),
    .command      (in_if.command),
    .timer_select (in_if.timer_select),
    .load_value   (in_if.load_value),
    .st_nxt       (st_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.display_strobe  = res_r.display_strobe;
  assign out_if.debounce_strobe = res_r.debounce_strobe;
  assign out_if.beep_off_pulse  = res_r.beep_off_pulse;
  assign out_if.blink_slow      = res_r.blink_slow;
  assign out_if.blink_fast      = res_r.blink_fast;
  assign out_if.short_user_left = res_r.short_user_left;
  assign out_if.long_user_left  = res_r.long_user_left;
  assign out_if.repeat_left     = res_r.repeat_left;
  assign out_if.beep_left       = res_r.beep_left;
  assign out_if.alarm_left      = res_r.alarm_left;
  assign out_if.snooze_left     = res_r.snooze_left;

endmodule

// ----- sv/mrtt_checker.sv -----
// port-level checks for the timer bank, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrtt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       display_strobe,
  input logic       debounce_strobe,
  input logic       beep_off_pulse,
  input logic [7:0] beep_left
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `ASSERT_IMPLIES(a_debounce_on_tick, clk, rst_n, out_valid && debounce_strobe, display_strobe)
  `ASSERT_IMPLIES(a_beep_off_zero, clk, rst_n, out_valid && beep_off_pulse, (beep_left == 8'd0) && debounce_strobe)

endmodule

bind multi_rate_tick_timer_bank mrtt_checker u_mrtt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .display_strobe  (out_if.display_strobe),
  .debounce_strobe (out_if.debounce_strobe),
  .beep_off_pulse  (out_if.beep_off_pulse),
  .beep_left       (out_if.beep_left)
);
